>>> rtl/indexed_list_engine_assert.svh
// Assertion helpers for the list engine; clk_i and rst_ni must be in scope.
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define ILE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("list engine check failed");

// next-cycle implication
`define ILE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

>>> rtl/ile_pkg.sv
package ile_pkg;

  localparam int POS_W    = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT,
    CMD_DELETE,
    CMD_READ,
    CMD_DUMP
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED,
    ST_INS_REJ,
    ST_DELETED,
    ST_DEL_REJ,
    ST_READ,
    ST_READ_INV,
    ST_DUMP_ITEM,
    ST_DUMP_EMPTY
  } status_e;

  // per-cell update: keep, take the load bus, take left or right neighbor
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

endpackage

>>> rtl/ile_cell.sv
module ile_cell import ile_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  cell_op_e               op_i,
  input  logic [VALUE_WIDTH-1:0] load_i,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  output logic [VALUE_WIDTH-1:0] data_o
);

  logic [VALUE_WIDTH-1:0] data_q, data_d;

  always_comb begin
    case (op_i)
      CELL_HOLD:  data_d = data_q;
      CELL_LOAD:  data_d = load_i;
      CELL_LEFT:  data_d = left_i;
      CELL_RIGHT: data_d = right_i;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> rtl/indexed_list_engine.sv
// Channel   Dir  tdata (low bit up)          tuser      tlast
// s_axis    in   position[8], value_in[VW]   cmd[2]     -
// m_axis    out  position_out[8], value_out  status[3]  last
//
// Insert and delete shift the cell row in place and read leaves it as is; the single
// result goes to the output register, so one such command per cycle unless the output stalls or a dump runs.
// A dump of N entries is the input transfer, then one output transfer per entry
// while the row rotates. An empty dump gives a single ST_DUMP_EMPTY output.
// Reset clears the count; entry contents are not cleared.
// A stalled output register holds the input off; dumps advance only while the output register is free.
module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  input  logic [((POS_W + VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // position, value_in
  input  logic [CMD_W-1:0]                              s_axis_tuser,  // cmd
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  output logic [((POS_W + VALUE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,  // position_out, value_out
  output logic [STATUS_W-1:0]                           m_axis_tuser,  // status
  output logic                                          m_axis_tlast
);

  localparam int OUT_W = ((POS_W + VALUE_WIDTH + 7) / 8) * 8;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   last_q, last_d;
  logic                   out_load;

  cmd_e                   cmd;
  logic [POS_W-1:0]       pos;
  logic [VALUE_WIDTH-1:0] val;
  logic [POS_W-1:0]       cnt_ext;
  logic [CNT_W-1:0]       cnt_m1;
  logic                   ins_ok, at_ok, out_free, in_fire, dump_last;
  logic [VALUE_WIDTH-1:0] rd_val, load_data;
  logic [VALUE_WIDTH-1:0] cell_q [CAPACITY];
  cell_op_e               ops [CAPACITY];

  assign cmd       = cmd_e'(s_axis_tuser);
  assign pos       = s_axis_tdata[POS_W-1:0];
  assign val       = s_axis_tdata[POS_W +: VALUE_WIDTH];
  assign cnt_ext   = POS_W'(count_q);
  assign cnt_m1    = count_q - CNT_W'(1);
  assign ins_ok    = !pos[POS_W-1] && (pos <= cnt_ext) && (count_q != CNT_W'(CAPACITY));
  assign at_ok     = !pos[POS_W-1] && (pos < cnt_ext);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign dump_last = (idx_q == cnt_m1);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_q[g+1];
    end
    ile_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (ops[g]),
      .load_i (load_data),
      .left_i (left),
      .right_i(right),
      .data_o (cell_q[g])
    );
  end

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (POS_W'(i) == pos) begin
        rd_val = rd_val | cell_q[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_load    = 1'b0;
    status_d    = ST_INSERTED;
    pos_d       = pos;
    value_d     = '0;
    last_d      = 1'b1;
    load_data   = val;
    for (int i = 0; i < CAPACITY; i++) begin
      ops[i] = CELL_HOLD;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          case (cmd)
            CMD_INSERT: begin
              if (ins_ok) begin
                status_d = ST_INSERTED;
                count_d  = count_q + CNT_W'(1);
                for (int i = 0; i < CAPACITY; i++) begin
                  if (POS_W'(i) == pos) begin
                    ops[i] = CELL_LOAD;
                  end else if (POS_W'(i) > pos && POS_W'(i) <= cnt_ext) begin
                    ops[i] = CELL_LEFT;
                  end
                end
              end else begin
                status_d = ST_INS_REJ;
              end
            end
            CMD_DELETE: begin
              if (at_ok) begin
                status_d = ST_DELETED;
                value_d  = rd_val;
                count_d  = cnt_m1;
                for (int i = 0; i < CAPACITY; i++) begin
                  if (POS_W'(i) >= pos && POS_W'(i) < POS_W'(cnt_m1)) begin
                    ops[i] = CELL_RIGHT;
                  end
                end
              end else begin
                status_d = ST_DEL_REJ;
              end
            end
            CMD_READ: begin
              if (at_ok) begin
                status_d = ST_READ;
                value_d  = rd_val;
              end else begin
                status_d = ST_READ_INV;
              end
            end
            CMD_DUMP: begin
              if (count_q == '0) begin
                status_d = ST_DUMP_EMPTY;
                pos_d    = '0;
              end else begin
                out_load = 1'b0;
                state_d  = S_DUMP;
                idx_d    = '0;
              end
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      S_DUMP: begin
        // rotate: head goes out and wraps to the tail of the valid range
        if (out_free) begin
          out_load  = 1'b1;
          status_d  = ST_DUMP_ITEM;
          pos_d     = POS_W'(idx_q);
          value_d   = cell_q[0];
          last_d    = dump_last;
          load_data = cell_q[0];
          idx_d     = idx_q + CNT_W'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) == cnt_m1) begin
              ops[i] = CELL_LOAD;
            end else if (CNT_W'(i) < cnt_m1) begin
              ops[i] = CELL_RIGHT;
            end
          end
          if (dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      pos_q    <= pos_d;
      value_q  <= value_d;
      last_q   <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = OUT_W'({value_q, pos_q});

`include "indexed_list_engine_assert.svh"

  `ILE_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
  `ILE_ASSERT_IMP(a_no_take_in_dump, state_q == S_DUMP, !s_axis_tready)
  `ILE_ASSERT_NXT(a_insert_grows, in_fire && cmd == CMD_INSERT && ins_ok, count_q == $past(count_q) + CNT_W'(1))
  `ILE_ASSERT_NXT(a_dump_no_count_change, state_q == S_DUMP, count_q == $past(count_q))

endmodule
